[rtl/core/udpq_pkg.sv]
`timescale 1ns / 1ps
package udpq_pkg;

  localparam int BIND_SLOTS  = 64;
  localparam int QUEUE_DEPTH = 16;
  localparam int MAX_PAYLOAD = 4096;

  localparam int SLOT_W   = $clog2(BIND_SLOTS);
  localparam int QPTR_W   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int LEN_W    = $clog2(MAX_PAYLOAD + 1);
  localparam int ENTRIES  = BIND_SLOTS * QUEUE_DEPTH;
  localparam int QWORD_W  = 2 * QPTR_W + QCNT_W;
  localparam int EWORD_W  = 32 + 16 + LEN_W + 16;

  typedef enum logic [1:0] {
    MODE_BIND = 2'd0,
    MODE_ENQ  = 2'd1,
    MODE_RECV = 2'd2,
    MODE_NONE = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_UNBOUND   = 3'd1,
    ST_TBL_FULL  = 3'd2,
    ST_Q_FULL    = 3'd3,
    ST_Q_EMPTY   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_MATCH,
    FSM_ENC,
    FSM_QRD,
    FSM_EXEC,
    FSM_OUT
  } fsm_t;

  typedef struct packed {
    logic load_in;
    logic match;
    logic enc;
    logic q_rd;
    logic exec;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic out_valid;
  } sts_t;

endpackage

[rtl/core/udpq_ram.sv]
`timescale 1ns / 1ps
module udpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/udpq_ctrl.sv]
`timescale 1ns / 1ps
module udpq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              out_ready,
  input  udpq_pkg::sts_t    sts,
  output udpq_pkg::cmd_t    cmd
);

  udpq_pkg::fsm_t state_r, state_nxt;
  logic out_free;

  assign out_free = !sts.out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= udpq_pkg::FSM_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      udpq_pkg::FSM_IDLE:  if (in_valid) state_nxt = udpq_pkg::FSM_MATCH;
      udpq_pkg::FSM_MATCH: state_nxt = udpq_pkg::FSM_ENC;
      udpq_pkg::FSM_ENC:   state_nxt = udpq_pkg::FSM_QRD;
      udpq_pkg::FSM_QRD:   state_nxt = udpq_pkg::FSM_EXEC;
      udpq_pkg::FSM_EXEC:  state_nxt = udpq_pkg::FSM_OUT;
      udpq_pkg::FSM_OUT:   if (out_free) state_nxt = udpq_pkg::FSM_IDLE;
      default:             state_nxt = udpq_pkg::FSM_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      udpq_pkg::FSM_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      udpq_pkg::FSM_MATCH: cmd.match    = 1'b1;
      udpq_pkg::FSM_ENC:   cmd.enc      = 1'b1;
      udpq_pkg::FSM_QRD:   cmd.q_rd     = 1'b1;
      udpq_pkg::FSM_EXEC:  cmd.exec     = 1'b1;
      udpq_pkg::FSM_OUT:   cmd.load_out = out_free;
      default:             cmd          = '0;
    endcase
  end

endmodule

[rtl/core/udpq_dp.sv]
`timescale 1ns / 1ps
module udpq_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  udpq_pkg::cmd_t               cmd,
  output udpq_pkg::sts_t               sts,
  input  logic [1:0]                   in_mode,
  input  logic [15:0]                  in_port,
  input  logic [31:0]                  in_src_ip,
  input  logic [15:0]                  in_src_port,
  input  logic [15:0]                  in_pkt_len,
  input  logic [15:0]                  in_buffer_tag,
  input  logic [15:0]                  in_max_len,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic [2:0]                   out_status,
  output logic [31:0]                  out_src_ip,
  output logic [15:0]                  out_src_port,
  output logic [udpq_pkg::LEN_W-1:0]   out_copy_len,
  output logic [15:0]                  out_buffer_tag
);

  localparam int SW = udpq_pkg::SLOT_W;
  localparam int PW = udpq_pkg::QPTR_W;
  localparam int CW = udpq_pkg::QCNT_W;
  localparam int LW = udpq_pkg::LEN_W;
  localparam int NS = udpq_pkg::BIND_SLOTS;

  // latched transaction
  udpq_pkg::mode_t mode_r;
  logic [15:0]     port_r;
  logic [31:0]     ip_r;
  logic [15:0]     sport_r;
  logic [LW-1:0]   len_r;
  logic [15:0]     tag_r;
  logic [15:0]     maxlen_r;

  // bind table
  logic [NS-1:0]   slot_used_r;
  logic [15:0]     slot_port_r [NS];

  logic [NS-1:0]   match_r;
  logic [NS-1:0]   free_r;
  logic            hit_r, hit_nxt;
  logic [SW-1:0]   slot_r, slot_nxt;
  logic            free_ok_r, free_ok_nxt;
  logic [SW-1:0]   free_idx_r, free_idx_nxt;

  udpq_pkg::status_t status_r, status_nxt;
  logic            pop_r;

  logic [LW-1:0]   len_clamp;

  // queue pointer memory
  logic                       q_we;
  logic [SW-1:0]              q_waddr;
  logic [udpq_pkg::QWORD_W-1:0] q_wdata, q_rdata;
  logic [PW-1:0]              q_head, q_tail;
  logic [CW-1:0]              q_count;

  // descriptor memory
  logic                       e_we, e_re;
  logic [SW+PW-1:0]           e_waddr, e_raddr;
  logic [udpq_pkg::EWORD_W-1:0] e_wdata, e_rdata;
  logic [31:0]                e_ip;
  logic [15:0]                e_sport;
  logic [LW-1:0]              e_len;
  logic [15:0]                e_tag;
  logic [LW-1:0]              copy_len;

  logic            out_valid_r;
  logic [2:0]      out_status_r;
  logic [31:0]     out_ip_r;
  logic [15:0]     out_sport_r;
  logic [LW-1:0]   out_len_r;
  logic [15:0]     out_tag_r;

  assign len_clamp = (in_pkt_len > 16'(udpq_pkg::MAX_PAYLOAD))
                     ? LW'(udpq_pkg::MAX_PAYLOAD) : in_pkt_len[LW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      mode_r   <= udpq_pkg::mode_t'(in_mode);
      port_r   <= in_port;
      ip_r     <= in_src_ip;
      sport_r  <= in_src_port;
      len_r    <= len_clamp;
      tag_r    <= in_buffer_tag;
      maxlen_r <= in_max_len;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.match) begin
      for (int i = 0; i < NS; i++) begin
        match_r[i] <= slot_used_r[i] && (slot_port_r[i] == port_r);
        free_r[i]  <= !slot_used_r[i];
      end
    end
  end

  // lowest set bit wins
  always_comb begin
    hit_nxt      = 1'b0;
    slot_nxt     = '0;
    free_ok_nxt  = 1'b0;
    free_idx_nxt = '0;
    for (int i = NS - 1; i >= 0; i--) begin
      if (match_r[i]) begin
        hit_nxt  = 1'b1;
        slot_nxt = SW'(i);
      end
      if (free_r[i]) begin
        free_ok_nxt  = 1'b1;
        free_idx_nxt = SW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.enc) begin
      hit_r      <= hit_nxt;
      slot_r     <= slot_nxt;
      free_ok_r  <= free_ok_nxt;
      free_idx_r <= free_idx_nxt;
    end
  end

  assign {q_head, q_tail, q_count} = q_rdata;

  always_comb begin
    status_nxt = udpq_pkg::ST_UNBOUND;
    q_we       = 1'b0;
    q_waddr    = slot_r;
    q_wdata    = q_rdata;
    e_we       = 1'b0;
    e_re       = 1'b0;
    e_waddr    = {slot_r, q_tail};
    e_raddr    = {slot_r, q_head};
    e_wdata    = {ip_r, sport_r, len_r, tag_r};
    case (mode_r)
      udpq_pkg::MODE_BIND: begin
        if (hit_r) begin
          status_nxt = udpq_pkg::ST_OK;
        end else if (free_ok_r) begin
          status_nxt = udpq_pkg::ST_OK;
          q_we       = cmd.exec;
          q_waddr    = free_idx_r;
          q_wdata    = '0;
        end else begin
          status_nxt = udpq_pkg::ST_TBL_FULL;
        end
      end
      udpq_pkg::MODE_ENQ: begin
        if (!hit_r) begin
          status_nxt = udpq_pkg::ST_UNBOUND;
        end else if (q_count == CW'(udpq_pkg::QUEUE_DEPTH)) begin
          status_nxt = udpq_pkg::ST_Q_FULL;
        end else begin
          status_nxt = udpq_pkg::ST_OK;
          e_we       = cmd.exec;
          q_we       = cmd.exec;
          q_wdata    = {q_head, q_tail + PW'(1), q_count + CW'(1)};
        end
      end
      udpq_pkg::MODE_RECV: begin
        if (!hit_r) begin
          status_nxt = udpq_pkg::ST_UNBOUND;
        end else if (q_count == '0) begin
          status_nxt = udpq_pkg::ST_Q_EMPTY;
        end else begin
          status_nxt = udpq_pkg::ST_OK;
          e_re       = cmd.exec;
          q_we       = cmd.exec;
          q_wdata    = {q_head + PW'(1), q_tail, q_count - CW'(1)};
        end
      end
      default: status_nxt = udpq_pkg::ST_UNBOUND;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_used_r <= '0;
    end else if (cmd.exec && mode_r == udpq_pkg::MODE_BIND && !hit_r && free_ok_r) begin
      slot_used_r[free_idx_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && mode_r == udpq_pkg::MODE_BIND && !hit_r && free_ok_r) begin
      slot_port_r[free_idx_r] <= port_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status_r <= status_nxt;
      pop_r    <= e_re;
    end
  end

  udpq_ram #(
    .WIDTH (udpq_pkg::QWORD_W),
    .DEPTH (udpq_pkg::BIND_SLOTS)
  ) u_qram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .re    (cmd.q_rd),
    .raddr (slot_r),
    .rdata (q_rdata)
  );

  udpq_ram #(
    .WIDTH (udpq_pkg::EWORD_W),
    .DEPTH (udpq_pkg::ENTRIES)
  ) u_eram (
    .clk   (clk),
    .we    (e_we),
    .waddr (e_waddr),
    .wdata (e_wdata),
    .re    (e_re),
    .raddr (e_raddr),
    .rdata (e_rdata)
  );

  assign {e_ip, e_sport, e_len, e_tag} = e_rdata;
  assign copy_len = (maxlen_r < 16'(e_len)) ? maxlen_r[LW-1:0] : e_len;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status_r <= status_r;
      out_ip_r     <= pop_r ? e_ip : '0;
      out_sport_r  <= pop_r ? e_sport : '0;
      out_len_r    <= pop_r ? copy_len : '0;
      out_tag_r    <= pop_r ? e_tag : '0;
    end
  end

  assign sts.out_valid  = out_valid_r;
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_src_ip     = out_ip_r;
  assign out_src_port   = out_sport_r;
  assign out_copy_len   = out_len_r;
  assign out_buffer_tag = out_tag_r;

endmodule

[rtl/core/udp_port_demux_queues_core.sv]
`timescale 1ns / 1ps
// udp port demultiplexer with a descriptor fifo per bound port: bind, enqueue and
// receive, one result transaction per input transaction; after acceptance the
// transaction passes through parallel port compare, registered priority encode,
// pointer memory read, descriptor memory write or read and output load, and the next
// transaction is taken the cycle after the result register loads, so only one
// transaction is in flight at a time; a result held by out_ready stalls the input
module udp_port_demux_queues_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [15:0] in_port,
  input  logic [31:0] in_src_ip,
  input  logic [15:0] in_src_port,
  input  logic [15:0] in_pkt_len,
  input  logic [15:0] in_buffer_tag,
  input  logic [15:0] in_max_len,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [31:0] out_src_ip,
  output logic [15:0] out_src_port,
  output logic [12:0] out_copy_len,
  output logic [15:0] out_buffer_tag
);

  udpq_pkg::cmd_t cmd;
  udpq_pkg::sts_t sts;

  udpq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  udpq_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_mode        (in_mode),
    .in_port        (in_port),
    .in_src_ip      (in_src_ip),
    .in_src_port    (in_src_port),
    .in_pkt_len     (in_pkt_len),
    .in_buffer_tag  (in_buffer_tag),
    .in_max_len     (in_max_len),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_src_ip     (out_src_ip),
    .out_src_port   (out_src_port),
    .out_copy_len   (out_copy_len),
    .out_buffer_tag (out_buffer_tag)
  );

`ifndef SYNTHESIS
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("transaction accepted while busy");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == udpq_pkg::ST_OK || out_status == udpq_pkg::ST_UNBOUND ||
                   out_status == udpq_pkg::ST_TBL_FULL || out_status == udpq_pkg::ST_Q_FULL ||
                   out_status == udpq_pkg::ST_Q_EMPTY))
    else $error("bad status code");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != udpq_pkg::ST_OK |->
      out_src_ip == '0 && out_src_port == '0 && out_copy_len == '0 && out_buffer_tag == '0)
    else $error("data on failed result");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_copy_len <= 13'(udpq_pkg::MAX_PAYLOAD))
    else $error("copy length above page size");
`endif

endmodule

[verif/udp_port_demux_queues_core_tb.sv]
`timescale 1ns / 1ps
module udp_port_demux_queues_core_tb;

  typedef struct {
    udpq_pkg::mode_t mode;
    logic [15:0]     port;
    logic [31:0]     src_ip;
    logic [15:0]     src_port;
    logic [15:0]     pkt_len;
    logic [15:0]     buffer_tag;
    logic [15:0]     max_len;
  } pkt_req_t;

  typedef struct {
    udpq_pkg::status_t status;
    logic [31:0]       src_ip;
    logic [15:0]       src_port;
    logic [12:0]       copy_len;
    logic [15:0]       buffer_tag;
  } pkt_resp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_mode = '0;
  logic [15:0] in_port = '0;
  logic [31:0] in_src_ip = '0;
  logic [15:0] in_src_port = '0;
  logic [15:0] in_pkt_len = '0;
  logic [15:0] in_buffer_tag = '0;
  logic [15:0] in_max_len = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] out_status;
  logic [31:0] out_src_ip;
  logic [15:0] out_src_port;
  logic [12:0] out_copy_len;
  logic [15:0] out_buffer_tag;

  udp_port_demux_queues_core u_dut (.*);

  always #2 clk = ~clk;

  // shadow of the port table and descriptor fifos
  logic        bound[udpq_pkg::BIND_SLOTS];
  logic [15:0] bound_port[udpq_pkg::BIND_SLOTS];
  pkt_resp_t   fifo_q[udpq_pkg::BIND_SLOTS][$];
  logic [12:0] fifo_len[udpq_pkg::BIND_SLOTS][$];

  pkt_req_t  pending_q[$];
  pkt_resp_t expected_q[$];
  int errors = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off = 0;
  logic [15:0] port_pool[$];

  function automatic pkt_resp_t demux_predict(pkt_req_t r);
    pkt_resp_t res;
    pkt_resp_t d;
    logic [12:0] ln;
    int s;
    res = '{udpq_pkg::ST_UNBOUND, '0, '0, '0, '0};
    s = -1;
    for (int i = 0; i < udpq_pkg::BIND_SLOTS; i++)
      if (s < 0 && bound[i] && bound_port[i] == r.port) s = i;
    case (r.mode)
      udpq_pkg::MODE_BIND: begin
        if (s >= 0) res.status = udpq_pkg::ST_OK;
        else begin
          res.status = udpq_pkg::ST_TBL_FULL;
          for (int i = 0; i < udpq_pkg::BIND_SLOTS; i++)
            if (res.status != udpq_pkg::ST_OK && !bound[i]) begin
              bound[i] = 1'b1;
              bound_port[i] = r.port;
              fifo_q[i].delete();
              fifo_len[i].delete();
              res.status = udpq_pkg::ST_OK;
            end
        end
      end
      udpq_pkg::MODE_ENQ: begin
        if (s < 0) res.status = udpq_pkg::ST_UNBOUND;
        else if (fifo_q[s].size() >= udpq_pkg::QUEUE_DEPTH) res.status = udpq_pkg::ST_Q_FULL;
        else begin
          d = '{udpq_pkg::ST_OK, r.src_ip, r.src_port, '0, r.buffer_tag};
          fifo_q[s].push_back(d);
          fifo_len[s].push_back(r.pkt_len > udpq_pkg::MAX_PAYLOAD
                                ? 13'(udpq_pkg::MAX_PAYLOAD) : 13'(r.pkt_len));
          res.status = udpq_pkg::ST_OK;
        end
      end
      udpq_pkg::MODE_RECV: begin
        if (s < 0) res.status = udpq_pkg::ST_UNBOUND;
        else if (fifo_q[s].size() == 0) res.status = udpq_pkg::ST_Q_EMPTY;
        else begin
          res = fifo_q[s].pop_front();
          ln = fifo_len[s].pop_front();
          res.copy_len = (ln < r.max_len) ? ln : 13'(r.max_len);
          res.status = udpq_pkg::ST_OK;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    errors++;
  endtask

  // driver
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n) begin
      if (!in_valid || in_ready) begin
        if (in_valid) expected_q.push_back(demux_predict(pending_q.pop_front()));
        if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          pkt_req_t n;
          n = pending_q[0];
          in_valid <= 1'b1;
          in_mode <= n.mode;
          in_port <= n.port;
          in_src_ip <= n.src_ip;
          in_src_port <= n.src_port;
          in_pkt_len <= n.pkt_len;
          in_buffer_tag <= n.buffer_tag;
          in_max_len <= n.max_len;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result transaction", out_status, '0);
        end else begin
          pkt_resp_t e;
          e = expected_q.pop_front();
          if (out_status != e.status) report_mismatch("status", out_status, e.status);
          if (out_src_ip != e.src_ip) report_mismatch("src_ip", out_src_ip, e.src_ip);
          if (out_src_port != e.src_port)
            report_mismatch("src_port", out_src_port, e.src_port);
          if (out_copy_len != e.copy_len)
            report_mismatch("copy_len", out_copy_len, e.copy_len);
          if (out_buffer_tag != e.buffer_tag)
            report_mismatch("buffer_tag", out_buffer_tag, e.buffer_tag);
        end
      end
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > 400000) begin
      $display("udp_port_demux_queues_core_tb: errors");
      $finish;
    end
  end

  function automatic pkt_req_t make_req(udpq_pkg::mode_t m, logic [15:0] p);
    pkt_req_t r;
    r.mode = m;
    r.port = p;
    r.src_ip = $urandom;
    r.src_port = 16'($urandom);
    case ($urandom_range(3))
      0: r.pkt_len = 16'($urandom_range(udpq_pkg::MAX_PAYLOAD - 2, udpq_pkg::MAX_PAYLOAD + 2));
      1: r.pkt_len = 16'($urandom);
      default: r.pkt_len = 16'($urandom_range(udpq_pkg::MAX_PAYLOAD));
    endcase
    r.buffer_tag = 16'($urandom);
    case ($urandom_range(3))
      0: r.max_len = 16'($urandom);
      1: r.max_len = 16'hffff;
      default: r.max_len = 16'($urandom_range(udpq_pkg::MAX_PAYLOAD));
    endcase
    return r;
  endfunction

  task automatic push_req(udpq_pkg::mode_t m, logic [15:0] p);
    pending_q.push_back(make_req(m, p));
  endtask

  task automatic drain();
    wait (pending_q.size() == 0 && !in_valid && expected_q.size() == 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic random_phase(int n);
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if (k < 3) push_req(udpq_pkg::mode_t'($urandom_range(3)), 16'($urandom));
      else if (k < 15)
        push_req(udpq_pkg::MODE_BIND, port_pool[$urandom_range(port_pool.size() - 1)]);
      else if (k < 55)
        push_req(udpq_pkg::MODE_ENQ, port_pool[$urandom_range(port_pool.size() - 1)]);
      else push_req(udpq_pkg::MODE_RECV, port_pool[$urandom_range(port_pool.size() - 1)]);
    end
  endtask

  initial begin
    pkt_req_t r;
    for (int i = 0; i < udpq_pkg::BIND_SLOTS; i++) bound[i] = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    // directed: unbound, extremes, empty, full, long payload
    push_req(udpq_pkg::MODE_RECV, 16'h0000);
    push_req(udpq_pkg::MODE_ENQ, 16'hffff);
    push_req(udpq_pkg::MODE_NONE, 16'hffff);
    push_req(udpq_pkg::MODE_BIND, 16'h0000);
    push_req(udpq_pkg::MODE_BIND, 16'hffff);
    push_req(udpq_pkg::MODE_BIND, 16'hffff);
    push_req(udpq_pkg::MODE_RECV, 16'hffff);
    r = make_req(udpq_pkg::MODE_ENQ, 16'hffff);
    r.src_ip = '1; r.src_port = '1; r.pkt_len = '1; r.buffer_tag = '1;
    pending_q.push_back(r);
    r.src_ip = '0; r.src_port = '0; r.pkt_len = '0; r.buffer_tag = '0;
    r.port = 16'h0000;
    pending_q.push_back(r);
    r = make_req(udpq_pkg::MODE_RECV, 16'hffff); r.max_len = '1; pending_q.push_back(r);
    r = make_req(udpq_pkg::MODE_RECV, 16'h0000); r.max_len = '0; pending_q.push_back(r);
    for (int i = 0; i < udpq_pkg::QUEUE_DEPTH + 1; i++) push_req(udpq_pkg::MODE_ENQ, 16'h0000);
    drain();
    // fill the table with the pool of ports
    port_pool.push_back(16'h0000);
    port_pool.push_back(16'hffff);
    for (int i = 0; i < udpq_pkg::BIND_SLOTS - 2; i++) begin
      port_pool.push_back(16'(16'h0100 + i * 16'h0101));
      push_req(udpq_pkg::MODE_BIND, port_pool[$]);
    end
    for (int i = 0; i < 4; i++) push_req(udpq_pkg::MODE_BIND, 16'($urandom) | 16'h8001);
    for (int i = 0; i < 4; i++) port_pool.push_back(16'($urandom) | 16'h4000);
    drain();
    random_phase(150);
    drain();
    send_idle_pct = 83;
    random_phase(120);
    drain();
    send_idle_pct = 0; recv_stall_pct = 83;
    random_phase(120);
    drain();
    send_idle_pct = 38; recv_stall_pct = 38;
    random_phase(120);
    drain();
    send_idle_pct = 0; recv_stall_pct = 0;
    @(posedge clk);
    hold_off <= 400;
    random_phase(60);
    drain();
    if (errors == 0) $display("udp_port_demux_queues_core_tb: clean");
    else $display("udp_port_demux_queues_core_tb: errors");
    $finish;
  end

endmodule

[filelist.f]
rtl/core/udpq_pkg.sv
rtl/core/udpq_ram.sv
rtl/core/udpq_ctrl.sv
rtl/core/udpq_dp.sv
rtl/core/udp_port_demux_queues_core.sv
verif/udp_port_demux_queues_core_tb.sv
